[rtl/core/bcm_pkg.sv]
// Shared types and constants for the bipartite capacity matcher.
// Used by bipartite_capacity_matcher and its testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bcm_pkg;
   localparam int OP_W  = 2;
   localparam int ERR_W = 2;
   localparam int OUT_COUNT_W = 11;
   localparam int CAP_W = 11;
   localparam int ADJ_W = 16;
   localparam int RIDX_W = 4;
   localparam int RCOUNT_W = 5;

   localparam logic [OP_W-1:0] OP_SET_CAP = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD     = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_LEFT_FULL = 2'd1;
   localparam logic [ERR_W-1:0] ERR_RIGHT_IDX = 2'd2;

   localparam logic [RCOUNT_W-1:0] RIGHT_COUNT_RESET = 5'd16;

   typedef logic [ADJ_W-1:0] adj_type;
endpackage
`default_nettype wire

[rtl/core/bcm_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Used by bipartite_capacity_matcher; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bcm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire                     rd_en,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

[rtl/core/bipartite_capacity_matcher.sv]
// Incremental many-to-one bipartite matcher with a depth-first augmenting search.
// Depends on bcm_pkg and bcm_ram.
// Capacity write, clear and any add that is not searched go straight to the done state after accept.
// A searched add scans the right nodes, tries each occupant of a full node through its occupant
// and adjacency reads, and unwinds the search stack before the response is formed.
// One word at a time; a new word may enter as the response leaves. Sync reset clears state.
`timescale 1ns / 1ps
`default_nettype none
module bipartite_capacity_matcher #(
   parameter int MAX_RIGHT = 16,
   parameter int MAX_LEFT  = 1024
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire [bcm_pkg::OP_W-1:0]          req_operation,
   input  wire [bcm_pkg::RIDX_W-1:0]        req_right_index,
   input  wire [bcm_pkg::CAP_W-1:0]         req_capacity,
   input  wire [bcm_pkg::ADJ_W-1:0]         req_adjacency,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic                             rsp_matched,
   output logic [bcm_pkg::OUT_COUNT_W-1:0]  rsp_matched_count,
   output logic                             rsp_all_matched,
   output logic [bcm_pkg::ERR_W-1:0]        rsp_error,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [bcm_pkg::RCOUNT_W-1:0]      csr_right_count
);
   localparam int RW = (MAX_RIGHT > 1) ? $clog2(MAX_RIGHT) : 1;
   localparam int LW = $clog2(MAX_LEFT);
   localparam int CW = $clog2(MAX_LEFT + 1);
   localparam int SW = $clog2(MAX_RIGHT + 1);
   localparam int OCC_DEPTH = 1 << (RW + LW);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN     = 3'd1;
   localparam logic [2:0] ST_OCC_CHK  = 3'd2;
   localparam logic [2:0] ST_OCC_WAIT = 3'd3;
   localparam logic [2:0] ST_ADJ_WAIT = 3'd4;
   localparam logic [2:0] ST_RET      = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   typedef struct packed {
      logic [LW-1:0]            who;
      bcm_pkg::adj_type         mask;
      logic [RW-1:0]            r;
      logic [CW-1:0]            j;
   } frame_type;

   logic [2:0]                   state_ff;
   logic [bcm_pkg::RCOUNT_W-1:0] right_count_ff;
   logic [CW-1:0]                occ_cnt_ff [MAX_RIGHT];
   logic [CW-1:0]                cap_ff [MAX_RIGHT];
   logic [MAX_RIGHT-1:0]         visited_ff;
   logic [CW-1:0]                left_count_ff;
   logic [CW-1:0]                total_ff;
   logic                         failed_ff;
   logic                         ok_ff;
   logic                         matched_ff;
   logic [bcm_pkg::ERR_W-1:0]    err_ff;
   frame_type                    stack_ff [MAX_RIGHT];
   logic [SW-1:0]                sp_ff;
   logic [LW-1:0]                who_ff;
   bcm_pkg::adj_type             mask_ff;
   logic [bcm_pkg::RCOUNT_W-1:0] r_ff;
   logic [CW-1:0]                j_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_matched_ff;
   logic [bcm_pkg::OUT_COUNT_W-1:0] rsp_count_ff;
   logic                         rsp_all_ff;
   logic [bcm_pkg::ERR_W-1:0]    rsp_err_ff;

   logic [bcm_pkg::RCOUNT_W-1:0] limit;
   logic [RW-1:0]                ridx;
   logic [CW-1:0]                cnt_cur;
   logic                         accept;
   frame_type                    top;
   logic [SW-1:0]                sp_dec;
   logic [CW-1:0]                cap_sat;

   logic                         occ_we, occ_re;
   logic [RW+LW-1:0]             occ_waddr, occ_raddr;
   logic [LW-1:0]                occ_wdata, occ_rdata;
   logic                         adj_we, adj_re;
   logic [LW-1:0]                adj_waddr;
   bcm_pkg::adj_type             adj_rdata;

   assign limit = (32'(right_count_ff) > MAX_RIGHT) ? bcm_pkg::RCOUNT_W'(MAX_RIGHT)
                                                    : right_count_ff;
   assign ridx    = r_ff[RW-1:0];
   assign cnt_cur = occ_cnt_ff[ridx];
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept  = req_valid && req_ready;
   assign sp_dec  = sp_ff - SW'(1);
   assign top     = stack_ff[sp_dec[RW-1:0]];
   assign cap_sat = (32'(req_capacity) > MAX_LEFT) ? CW'(MAX_LEFT) : CW'(req_capacity);
   assign csr_ready = 1'b1;

   // Occupant RAM: a new occupant is appended in the scan, a displaced slot is
   // rewritten while a successful path unwinds.
   always_comb begin
      occ_we    = 1'b0;
      occ_waddr = {ridx, cnt_cur[LW-1:0]};
      occ_wdata = who_ff;
      if (state_ff == ST_SCAN) begin
         occ_we = (r_ff < limit) && mask_ff[ridx] && !visited_ff[ridx]
                  && (cnt_cur < cap_ff[ridx]);
      end else if (state_ff == ST_RET) begin
         occ_we    = ok_ff && (sp_ff != '0);
         occ_waddr = {top.r, top.j[LW-1:0]};
         occ_wdata = top.who;
      end
      occ_re    = (state_ff == ST_OCC_CHK) && (j_ff < cnt_cur);
      occ_raddr = {ridx, j_ff[LW-1:0]};
      adj_we    = accept && (req_operation == bcm_pkg::OP_ADD)
                  && (32'(left_count_ff) < MAX_LEFT);
      adj_waddr = left_count_ff[LW-1:0];
      adj_re    = (state_ff == ST_OCC_WAIT);
   end

   bcm_ram #(.WIDTH(LW), .DEPTH(OCC_DEPTH)) u_occ_ram (
      .clock(clock), .wr_en(occ_we), .wr_addr(occ_waddr), .wr_data(occ_wdata),
      .rd_en(occ_re), .rd_addr(occ_raddr), .rd_data(occ_rdata)
   );

   bcm_ram #(.WIDTH(bcm_pkg::ADJ_W), .DEPTH(1 << LW)) u_adj_ram (
      .clock(clock), .wr_en(adj_we), .wr_addr(adj_waddr), .wr_data(req_adjacency),
      .rd_en(adj_re), .rd_addr(occ_rdata), .rd_data(adj_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         right_count_ff <= bcm_pkg::RIGHT_COUNT_RESET;
         for (int k = 0; k < MAX_RIGHT; k++) begin
            occ_cnt_ff[k] <= '0;
            cap_ff[k]     <= '0;
         end
         visited_ff    <= '0;
         left_count_ff <= '0;
         total_ff      <= '0;
         failed_ff     <= 1'b0;
         ok_ff         <= 1'b0;
         matched_ff    <= 1'b0;
         err_ff        <= bcm_pkg::ERR_NONE;
         sp_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            right_count_ff <= csr_right_count;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  matched_ff <= 1'b0;
                  case (req_operation)
                     bcm_pkg::OP_SET_CAP: begin
                        state_ff <= ST_DONE;
                        if (32'(req_right_index) >= MAX_RIGHT) begin
                           err_ff <= bcm_pkg::ERR_RIGHT_IDX;
                        end else begin
                           err_ff <= bcm_pkg::ERR_NONE;
                           cap_ff[req_right_index[RW-1:0]] <= cap_sat;
                        end
                     end
                     bcm_pkg::OP_ADD: begin
                        if (32'(left_count_ff) >= MAX_LEFT) begin
                           err_ff   <= bcm_pkg::ERR_LEFT_FULL;
                           state_ff <= ST_DONE;
                        end else begin
                           err_ff        <= bcm_pkg::ERR_NONE;
                           left_count_ff <= left_count_ff + CW'(1);
                           if (!failed_ff) begin
                              visited_ff <= '0;
                              who_ff     <= left_count_ff[LW-1:0];
                              mask_ff    <= req_adjacency;
                              r_ff       <= '0;
                              sp_ff      <= '0;
                              state_ff   <= ST_SCAN;
                           end else begin
                              state_ff <= ST_DONE;
                           end
                        end
                     end
                     bcm_pkg::OP_CLEAR: begin
                        err_ff   <= bcm_pkg::ERR_NONE;
                        state_ff <= ST_DONE;
                        for (int k = 0; k < MAX_RIGHT; k++) begin
                           occ_cnt_ff[k] <= '0;
                        end
                        visited_ff    <= '0;
                        left_count_ff <= '0;
                        total_ff      <= '0;
                        failed_ff     <= 1'b0;
                     end
                     default: begin
                        err_ff   <= bcm_pkg::ERR_NONE;
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (r_ff >= limit) begin
                  ok_ff    <= 1'b0;
                  state_ff <= ST_RET;
               end else if (mask_ff[ridx] && !visited_ff[ridx]) begin
                  visited_ff[ridx] <= 1'b1;
                  if (cnt_cur < cap_ff[ridx]) begin
                     occ_cnt_ff[ridx] <= cnt_cur + CW'(1);
                     ok_ff            <= 1'b1;
                     state_ff         <= ST_RET;
                  end else begin
                     j_ff     <= '0;
                     state_ff <= ST_OCC_CHK;
                  end
               end else begin
                  r_ff <= r_ff + bcm_pkg::RCOUNT_W'(1);
               end
            end
            ST_OCC_CHK: begin
               if (j_ff < cnt_cur) begin
                  state_ff <= ST_OCC_WAIT;
               end else begin
                  r_ff     <= r_ff + bcm_pkg::RCOUNT_W'(1);
                  state_ff <= ST_SCAN;
               end
            end
            ST_OCC_WAIT: begin
               // Descend: park this frame and try to move the occupant elsewhere.
               stack_ff[sp_ff[RW-1:0]] <= '{who: who_ff, mask: mask_ff, r: ridx, j: j_ff};
               sp_ff    <= sp_ff + SW'(1);
               who_ff   <= occ_rdata;
               state_ff <= ST_ADJ_WAIT;
            end
            ST_ADJ_WAIT: begin
               mask_ff  <= adj_rdata;
               r_ff     <= '0;
               state_ff <= ST_SCAN;
            end
            ST_RET: begin
               if (sp_ff == '0) begin
                  if (ok_ff) begin
                     total_ff   <= total_ff + CW'(1);
                     matched_ff <= 1'b1;
                  end else begin
                     failed_ff <= 1'b1;
                  end
                  state_ff <= ST_DONE;
               end else begin
                  sp_ff <= sp_dec;
                  if (!ok_ff) begin
                     who_ff   <= top.who;
                     mask_ff  <= top.mask;
                     r_ff     <= bcm_pkg::RCOUNT_W'(top.r);
                     j_ff     <= top.j + CW'(1);
                     state_ff <= ST_OCC_CHK;
                  end
               end
            end
            ST_DONE: begin
               rsp_valid_ff   <= 1'b1;
               rsp_matched_ff <= matched_ff;
               rsp_count_ff   <= bcm_pkg::OUT_COUNT_W'(total_ff);
               rsp_all_ff     <= (total_ff == left_count_ff);
               rsp_err_ff     <= err_ff;
               state_ff       <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched       = rsp_matched_ff;
   assign rsp_matched_count = rsp_count_ff;
   assign rsp_all_matched   = rsp_all_ff;
   assign rsp_error         = rsp_err_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      32'(sp_ff) <= MAX_RIGHT)
      else $error("search stack overflow");
   a_total_le_left: assert property (@(posedge clock) disable iff (reset)
      total_ff <= left_count_ff)
      else $error("matched total exceeds left count");
   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> !rsp_valid_ff)
      else $error("result word overwritten");
   a_failed_gap: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> (total_ff != left_count_ff))
      else $error("sticky failure with everything matched");
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("word accepted during a search");
endmodule
`default_nettype wire
